FILE: rtl/core/gmr_pkg.sv
package gmr_pkg;

    localparam int SIDE        = 5;
    localparam logic [2:0] SIDE_MAX = 3'd4;
    localparam int GLYPH_BITS  = 25;
    localparam int BIT_W       = 13;   // bit offset of a line, up to 255*25+20
    localparam int X_W         = 10;   // byte offset of a line
    localparam int M_W         = 8;    // reciprocal width
    localparam int RECIP_SHIFT = 10;
    localparam int P_W         = X_W + M_W;
    localparam int Q_W         = P_W - RECIP_SHIFT;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [1:0] CFG_ROTATION   = 2'd0;
    localparam logic [1:0] CFG_FIRST_CHAR = 2'd1;
    localparam logic [1:0] CFG_NUM_CHARS  = 2'd2;

    localparam logic [1:0] ROT_COLS_UP   = 2'd0;
    localparam logic [1:0] ROT_ROWS_FLIP = 2'd1;
    localparam logic [1:0] ROT_COLS_FLIP = 2'd2;
    localparam logic [1:0] ROT_ROWS      = 2'd3;

    typedef struct packed {
        logic [1:0] rotation;
        logic [6:0] first_char;
        logic [7:0] num_chars;
    } t_cfg;

    // item leaving the sequencer: one load or one cell of a draw
    typedef struct packed {
        logic        vld;
        logic        is_load;
        logic [8:0]  addr;
        logic [7:0]  data_b;
        logic [7:0]  glyph;
        logic        gok;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [4:0]  sx;
        logic [4:0]  sy;
        logic [31:0] color;
        logic        last;
    } t_tok;

    typedef struct packed {
        logic        vld;
        logic        is_load;
        logic        wen;
        logic [8:0]  addr;
        logic [7:0]  data_b;
        logic        ok;
        logic [2:0]  f;
        logic [2:0]  scol;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] color;
        logic        last;
    } t_cel;

    function automatic logic [4:0] cell_index(input logic [1:0] rot,
                                              input logic [2:0] row,
                                              input logic [2:0] col);
        logic [4:0] r5;
        logic [4:0] c5;
        logic [4:0] m5;
        logic [4:0] s5;
        logic [4:0] res;
        r5 = {2'b00, row};
        c5 = {2'b00, col};
        m5 = 5'd4;
        s5 = 5'd5;
        unique case (rot)
            ROT_COLS_UP:   res = c5 * s5 + (col[0] ? r5 : m5 - r5);
            ROT_ROWS_FLIP: res = (m5 - r5) * s5 + (row[0] ? c5 : m5 - c5);
            ROT_COLS_FLIP: res = (m5 - c5) * s5 + (col[0] ? m5 - r5 : r5);
            ROT_ROWS:      res = r5 * s5 + (row[0] ? m5 - c5 : c5);
            default:       res = r5 * s5 + (row[0] ? m5 - c5 : c5);
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/glyph_matrix_renderer_core.sv
// Character generator for a 5x5 serpentine LED matrix.
// Input stream: tuser selects the item kind (0 = load one font byte, 1 = draw).
// A load writes one byte of the glyph store and produces no output item.
// A draw produces 25 output items, one per cell, row by row, with the strip
// index for the current rotation, the color for lit cells and tlast on the
// final cell.
// A draw occupies the input until the sequencer has issued all its cells, one
// cell per cycle while the output does not stall; a load does not hold the
// input busy.
// The store read stage fetches both bytes of a glyph line for each cell.
// Configuration writes (rotation, first character, glyph count) must go in
// while the block is idle; the block itself does not enforce this. Reset sets
// rotation 3, first character 32 and 96 glyphs and empties the pipeline; store
// contents stay undefined until loaded. When the output receiver stalls, the
// whole pipeline holds and the input is not taken; nothing is lost or repeated.
module glyph_matrix_renderer_core #(
    parameter int STORE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // font_address, font_byte, char_code, color,
                                         // shift_x, shift_y, zero fill
    input  logic        i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // pixel_index, pixel_color, lit, zero fill
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import gmr_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);

    t_cfg              r_cfg;
    logic              w_adv;
    t_tok              w_tok;
    t_cel              w_cel_a, w_cel_s;
    logic [ADDR_W-1:0] w_a0, w_a1;
    logic [15:0]       w_word;
    logic [4:0]        w_index;
    logic [31:0]       w_color;
    logic              w_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation   <= 2'd3;
            r_cfg.first_char <= 7'd32;
            r_cfg.num_chars  <= 8'd96;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROTATION:   r_cfg.rotation   <= i_cfg_data[1:0];
                CFG_FIRST_CHAR: r_cfg.first_char <= i_cfg_data[6:0];
                CFG_NUM_CHARS:  r_cfg.num_chars  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gmr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_s_vld  (i_s_axis_tvalid),
        .i_cmd    (i_s_axis_tuser),
        .i_addr   (i_s_axis_tdata[8:0]),
        .i_data_b (i_s_axis_tdata[16:9]),
        .i_code   (i_s_axis_tdata[24:17]),
        .i_color  (i_s_axis_tdata[56:25]),
        .i_sx     (i_s_axis_tdata[61:57]),
        .i_sy     (i_s_axis_tdata[66:62]),
        .i_cfg    (r_cfg),
        .o_ready  (o_s_axis_tready),
        .o_tok    (w_tok)
    );

    gmr_addr #(.STORE_BYTES(STORE_BYTES)) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tok   (w_tok),
        .o_cel   (w_cel_a),
        .o_a0    (w_a0),
        .o_a1    (w_a1)
    );

    gmr_store #(.STORE_BYTES(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cel   (w_cel_a),
        .i_a0    (w_a0),
        .i_a1    (w_a1),
        .o_cel   (w_cel_s),
        .o_word  (w_word)
    );

    gmr_pix u_pix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cel      (w_cel_s),
        .i_word     (w_word),
        .i_rotation (r_cfg.rotation),
        .i_m_ready  (i_m_axis_tready),
        .o_adv      (w_adv),
        .o_vld      (o_m_axis_tvalid),
        .o_index    (w_index),
        .o_color    (w_color),
        .o_lit      (w_lit),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_lit, w_color, w_index};

endmodule

FILE: rtl/core/gmr_seq.sv
module gmr_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_s_vld,
    input  logic          i_cmd,
    input  logic [8:0]    i_addr,
    input  logic [7:0]    i_data_b,
    input  logic [7:0]    i_code,
    input  logic [31:0]   i_color,
    input  logic [4:0]    i_sx,
    input  logic [4:0]    i_sy,
    input  gmr_pkg::t_cfg i_cfg,
    output logic          o_ready,
    output gmr_pkg::t_tok o_tok
);
    import gmr_pkg::*;

    logic        r_busy, n_busy;
    logic [7:0]  r_glyph, n_glyph;
    logic        r_gok, n_gok;
    logic [31:0] r_color, n_color;
    logic [4:0]  r_sx, n_sx;
    logic [4:0]  r_sy, n_sy;
    logic [2:0]  r_row, n_row;
    logic [2:0]  r_col, n_col;
    t_tok        r_tok, n_tok;
    logic        w_accept;
    logic        w_cell_last;
    logic [7:0]  w_diff;
    logic        w_in_range;

    always_comb begin
        o_ready     = !r_busy && i_adv;
        w_accept    = i_s_vld && o_ready;
        w_diff      = i_code - {1'b0, i_cfg.first_char};
        w_in_range  = (i_code >= {1'b0, i_cfg.first_char}) && (w_diff < i_cfg.num_chars);
        w_cell_last = (r_row == SIDE_MAX) && (r_col == SIDE_MAX);

        n_busy  = r_busy;
        n_glyph = r_glyph;
        n_gok   = r_gok;
        n_color = r_color;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_row   = r_row;
        n_col   = r_col;
        n_tok   = r_tok;

        if (i_adv) begin
            n_tok = '0;
            if (r_busy) begin
                n_tok.vld   = 1'b1;
                n_tok.glyph = r_glyph;
                n_tok.gok   = r_gok;
                n_tok.row   = r_row;
                n_tok.col   = r_col;
                n_tok.sx    = r_sx;
                n_tok.sy    = r_sy;
                n_tok.color = r_color;
                n_tok.last  = w_cell_last;
                // advance across the row, then down
                if (r_col == SIDE_MAX) begin
                    n_col = '0;
                    n_row = r_row + 3'd1;
                end else begin
                    n_col = r_col + 3'd1;
                end
                if (w_cell_last) begin
                    n_busy = 1'b0;
                end
            end else if (w_accept && i_cmd == CMD_LOAD) begin
                n_tok.vld     = 1'b1;
                n_tok.is_load = 1'b1;
                n_tok.addr    = i_addr;
                n_tok.data_b  = i_data_b;
            end
        end

        if (w_accept && i_cmd == CMD_DRAW) begin
            n_busy  = 1'b1;
            n_row   = '0;
            n_col   = '0;
            n_glyph = w_diff;
            n_gok   = w_in_range;
            n_color = i_color;
            n_sx    = i_sx;
            n_sy    = i_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
            r_tok  <= '0;
        end else begin
            r_busy <= n_busy;
            r_row  <= n_row;
            r_col  <= n_col;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        r_gok   <= n_gok;
        r_color <= n_color;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
    end

    assign o_tok = r_tok;

`ifndef SYNTHESIS
    a_draw_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == CMD_DRAW) |=> (r_busy && r_row == '0 && r_col == '0))
        else $error("draw accepted but cell walk did not start at the top left");
    a_draw_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_busy && w_cell_last) |=> !r_busy)
        else $error("sequencer still busy after the last cell");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready)
        else $error("input ready while a draw is in progress");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_tok))
        else $error("issued item changed during a stall");
`endif

endmodule

FILE: rtl/core/gmr_addr.sv
module gmr_addr #(
    parameter int STORE_BYTES = 512,
    localparam int ADDR_W = $clog2(STORE_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  gmr_pkg::t_tok     i_tok,
    output gmr_pkg::t_cel     o_cel,
    output logic [ADDR_W-1:0] o_a0,
    output logic [ADDR_W-1:0] o_a1
);
    import gmr_pkg::*;

    localparam int N_W   = $clog2(STORE_BYTES + 1);
    localparam int QN_W  = N_W + Q_W;
    localparam int RECIP = (1 << RECIP_SHIFT) / STORE_BYTES;

    // stage 1: source row/column and bit offset
    logic signed [5:0] w_src;
    logic signed [5:0] w_sc;
    logic [BIT_W-1:0]  w_bit;
    logic [QN_W-1:0]   w_fa;
    t_cel              n_c1;

    t_cel             r_c1, r_c2, r_c3, r_c4;
    logic [X_W-1:0]   r_x1, r_x2, r_x3;
    logic [P_W-1:0]   r_p2;
    logic [QN_W-1:0]  r_qn3;
    logic [ADDR_W-1:0] r_a0, r_a1;

    logic [Q_W-1:0]   w_q;
    logic [QN_W-1:0]  w_rem, w_remc, w_nxt, w_a1, w_wa;
    logic [ADDR_W-1:0] n_a0, n_a1;

    always_comb begin
        w_src = $signed({3'b000, i_tok.row}) - 6'($signed(i_tok.sy));
        w_sc  = $signed({3'b000, i_tok.col}) + 6'($signed(i_tok.sx));
        w_bit = BIT_W'(i_tok.glyph) * BIT_W'(GLYPH_BITS)
              + BIT_W'(w_src[2:0]) * BIT_W'(SIDE);
        w_fa  = QN_W'(i_tok.addr);

        n_c1         = '0;
        n_c1.vld     = i_tok.vld;
        n_c1.is_load = i_tok.is_load;
        n_c1.wen     = w_fa < QN_W'(STORE_BYTES);
        n_c1.addr    = i_tok.addr;
        n_c1.data_b  = i_tok.data_b;
        n_c1.ok      = i_tok.gok && (w_src >= 6'sd0) && (w_src <= 6'sd4)
                     && (w_sc >= 6'sd0) && (w_sc <= 6'sd4);
        n_c1.f       = w_bit[2:0];
        n_c1.scol    = w_sc[2:0];
        n_c1.row     = i_tok.row;
        n_c1.col     = i_tok.col;
        n_c1.color   = i_tok.color;
        n_c1.last    = i_tok.last;
    end

    // stage 3 and 4: byte offset modulo the store size by reciprocal
    always_comb begin
        w_q    = r_p2[P_W-1:RECIP_SHIFT];
        w_rem  = QN_W'(r_x3) - r_qn3;
        w_remc = (w_rem >= QN_W'(STORE_BYTES)) ? w_rem - QN_W'(STORE_BYTES) : w_rem;
        w_nxt  = w_remc + QN_W'(1);
        w_a1   = (w_nxt == QN_W'(STORE_BYTES)) ? '0 : w_nxt;
        w_wa   = QN_W'(r_c3.addr);
        n_a0   = r_c3.is_load ? w_wa[ADDR_W-1:0] : w_remc[ADDR_W-1:0];
        n_a1   = w_a1[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
        end else if (i_adv) begin
            r_c1 <= n_c1;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x1  <= w_bit[BIT_W-1:3];
            r_x2  <= r_x1;
            r_p2  <= P_W'(r_x1) * P_W'(RECIP);
            r_x3  <= r_x2;
            r_qn3 <= QN_W'(w_q) * QN_W'(STORE_BYTES);
            r_a0  <= n_a0;
            r_a1  <= n_a1;
        end
    end

    assign o_cel = r_c4;
    assign o_a0  = r_a0;
    assign o_a1  = r_a1;

endmodule

FILE: rtl/core/gmr_store.sv
module gmr_store #(
    parameter int STORE_BYTES = 512,
    localparam int ADDR_W = $clog2(STORE_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  gmr_pkg::t_cel     i_cel,
    input  logic [ADDR_W-1:0] i_a0,
    input  logic [ADDR_W-1:0] i_a1,
    output gmr_pkg::t_cel     o_cel,
    output logic [15:0]       o_word
);
    import gmr_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rd0, r_rd1;
    t_cel       r_cel;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_cel.vld && i_cel.is_load && i_cel.wen) begin
                r_mem[i_a0] <= i_cel.data_b;
            end
            r_rd0 <= r_mem[i_a0];
            r_rd1 <= r_mem[i_a1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cel <= '0;
        end else if (i_adv) begin
            r_cel <= i_cel;
        end
    end

    assign o_cel  = r_cel;
    assign o_word = {r_rd0, r_rd1};

endmodule

FILE: rtl/core/gmr_pix.sv
module gmr_pix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gmr_pkg::t_cel i_cel,
    input  logic [15:0]   i_word,
    input  logic [1:0]    i_rotation,
    input  logic          i_m_ready,
    output logic          o_adv,
    output logic          o_vld,
    output logic [4:0]    o_index,
    output logic [31:0]   o_color,
    output logic          o_lit,
    output logic          o_last
);
    import gmr_pkg::*;

    logic        r_vld;
    logic [4:0]  r_idx;
    logic [31:0] r_color;
    logic        r_lit;
    logic        r_last;
    logic [3:0]  w_sel;
    logic        w_on;

    always_comb begin
        o_adv = !r_vld || i_m_ready;
        // line sits at bits 15-f down to 11-f; pick the source column inside it
        w_sel = 4'd11 - {1'b0, i_cel.f} + {1'b0, i_cel.scol};
        w_on  = i_cel.ok && i_word[w_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_cel.vld && !i_cel.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_idx   <= cell_index(i_rotation, i_cel.row, i_cel.col);
            r_color <= w_on ? i_cel.color : '0;
            r_lit   <= w_on;
            r_last  <= i_cel.last;
        end
    end

    assign o_vld   = r_vld;
    assign o_index = r_idx;
    assign o_color = r_color;
    assign o_lit   = r_lit;
    assign o_last  = r_last;

endmodule
